>>> rtl/mdfs_pkg.sv
// ============================================================================
// Maze DFS path walker package
// Shared sizes, command and state codes, and the structs that travel between
// the controller and the top level.
// ============================================================================
package mdfs_pkg;

    // Grid and store sizes.
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
    localparam int CELL_AW    = $clog2(CELL_COUNT);
    localparam int COUNT_W    = CELL_AW + 1;
    localparam int COORD_W    = 6;
    localparam int DIM_W      = 7;
    localparam int LINK_W     = 4;
    localparam int CELL_W     = LINK_W + 1;
    localparam int PATH_W     = 2 * COORD_W;
    localparam int RND_W      = 16;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 1;

    // Bit of a cell word that marks it explored.
    localparam int EXPLORED_BIT = LINK_W;

    // Reset value of both grid size registers.
    localparam logic [DIM_W-1:0] GRID_RESET = 7'd10;

    // Reciprocal of three for the remainder by three: q = (v * RECIP3) >> 17.
    localparam int               RECIP3_SHIFT = 17;
    localparam logic [RECIP3_SHIFT-1:0] RECIP3 = 17'd43691;

    // Number of cell reads in one step: the current cell and four neighbours.
    localparam logic [2:0] READ_SLOTS = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    // Directions in the order in which open ones are listed.
    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } t_dir;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_ST_RD,
        S_ST_WR,
        S_BASE,
        S_READ,
        S_PICK,
        S_POP,
        S_RD_PATH,
        S_RESULT
    } t_state;

    // Effective grid size, always within 1..MAX.
    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } t_grid;

    typedef struct packed {
        logic               we;
        logic [CELL_AW-1:0] waddr;
        logic [CELL_W-1:0]  wdata;
        logic [CELL_AW-1:0] raddr;
    } t_cell_req;

    typedef struct packed {
        logic               we;
        logic [CELL_AW-1:0] waddr;
        logic [PATH_W-1:0]  wdata;
        logic [CELL_AW-1:0] raddr;
    } t_path_req;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COUNT_W-1:0] len;
        logic               done;
        logic               stuck;
    } t_result;

endpackage

>>> rtl/maze_dfs_path_walker_unit.sv
// ============================================================================
// Maze DFS path walker
// Randomised depth-first walk through a grid maze held in a cell store, with
// the walked path kept on a stack that can be read back.
// ============================================================================
// One command is taken at a time: start is accepted while busy is low, and
// its single result beat appears on o_valid for exactly one cycle, which the
// receiver cannot stall. A step that finds the walker done or stuck reads
// nothing; otherwise it reads the current cell and its four neighbours
// through the single read port of the cell store, one per cycle, and a
// backtrack then reloads the previous position from the path stack.
// ============================================================================
module maze_dfs_path_walker_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [mdfs_pkg::CMD_W-1:0]            i_command,
    input  logic [mdfs_pkg::CELL_AW-1:0]          i_cell_index,
    input  logic [mdfs_pkg::LINK_W-1:0]           i_cell_links,
    input  logic [mdfs_pkg::RND_W-1:0]            i_random_value,
    input  logic [mdfs_pkg::CELL_AW-1:0]          i_path_index,
    input  logic                                  i_cfg_we,
    input  logic [mdfs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mdfs_pkg::DIM_W-1:0]            i_cfg_data,
    output logic                                  o_valid,
    output logic [mdfs_pkg::COORD_W-1:0]          o_pos_x,
    output logic [mdfs_pkg::COORD_W-1:0]          o_pos_y,
    output logic [mdfs_pkg::COUNT_W-1:0]          o_path_length,
    output logic                                  o_done_res,
    output logic                                  o_stuck
);

    localparam int DW = mdfs_pkg::DIM_W;

    logic [DW-1:0]         r_grid_w;
    logic [DW-1:0]         r_grid_h;
    mdfs_pkg::t_grid       grid;
    mdfs_pkg::t_cell_req   cell_req;
    mdfs_pkg::t_path_req   path_req;
    mdfs_pkg::t_result     result;
    logic [mdfs_pkg::CELL_W-1:0] cell_rdata;
    logic [mdfs_pkg::PATH_W-1:0] path_rdata;

    // Grid size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= mdfs_pkg::GRID_RESET;
            r_grid_h <= mdfs_pkg::GRID_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mdfs_pkg::REG_GRID_WIDTH:  r_grid_w <= i_cfg_data;
                mdfs_pkg::REG_GRID_HEIGHT: r_grid_h <= i_cfg_data;
            endcase
        end
    end

    // Effective size: zero acts as one, oversize clamps to the maximum.
    always_comb begin
        if (r_grid_w == '0) begin
            grid.w = DW'(1);
        end else if (r_grid_w > DW'(mdfs_pkg::MAX_WIDTH)) begin
            grid.w = DW'(mdfs_pkg::MAX_WIDTH);
        end else begin
            grid.w = r_grid_w;
        end
        if (r_grid_h == '0) begin
            grid.h = DW'(1);
        end else if (r_grid_h > DW'(mdfs_pkg::MAX_HEIGHT)) begin
            grid.h = DW'(mdfs_pkg::MAX_HEIGHT);
        end else begin
            grid.h = r_grid_h;
        end
    end

    // Cell store: links plus explored mark.
    mdfs_ram #(
        .DEPTH (mdfs_pkg::CELL_COUNT),
        .WIDTH (mdfs_pkg::CELL_W)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_req.we),
        .i_waddr (cell_req.waddr),
        .i_wdata (cell_req.wdata),
        .i_raddr (cell_req.raddr),
        .o_rdata (cell_rdata)
    );

    // Path stack: column and row of each walked position.
    mdfs_ram #(
        .DEPTH (mdfs_pkg::CELL_COUNT),
        .WIDTH (mdfs_pkg::PATH_W)
    ) u_path_ram (
        .i_clk   (i_clk),
        .i_we    (path_req.we),
        .i_waddr (path_req.waddr),
        .i_wdata (path_req.wdata),
        .i_raddr (path_req.raddr),
        .o_rdata (path_rdata)
    );

    mdfs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_command      (i_command),
        .i_cell_index   (i_cell_index),
        .i_cell_links   (i_cell_links),
        .i_random_value (i_random_value),
        .i_path_index   (i_path_index),
        .i_grid         (grid),
        .i_cell_rdata   (cell_rdata),
        .i_path_rdata   (path_rdata),
        .o_cell_req     (cell_req),
        .o_path_req     (path_req),
        .o_busy         (busy),
        .o_result       (result)
    );

    // Result beat.
    assign o_valid       = result.valid;
    assign o_pos_x       = result.x;
    assign o_pos_y       = result.y;
    assign o_path_length = result.len;
    assign o_done_res    = result.done;
    assign o_stuck       = result.stuck;

endmodule

>>> rtl/mdfs_ram.sv
// ============================================================================
// Generic synchronous RAM
// One write port and one read port; read data is registered.
// ============================================================================
module mdfs_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/mdfs_ctrl.sv
// ============================================================================
// Maze DFS walker controller
// Sequences every command over the cell store and the path stack: reads the
// current cell and its neighbours, picks a direction, marks and pushes, or
// pops and backtracks. Holds the walker position, stack count and stuck flag.
// ============================================================================
module mdfs_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [mdfs_pkg::CMD_W-1:0]          i_command,
    input  logic [mdfs_pkg::CELL_AW-1:0]        i_cell_index,
    input  logic [mdfs_pkg::LINK_W-1:0]         i_cell_links,
    input  logic [mdfs_pkg::RND_W-1:0]          i_random_value,
    input  logic [mdfs_pkg::CELL_AW-1:0]        i_path_index,
    input  mdfs_pkg::t_grid                     i_grid,
    input  logic [mdfs_pkg::CELL_W-1:0]         i_cell_rdata,
    input  logic [mdfs_pkg::PATH_W-1:0]         i_path_rdata,
    output mdfs_pkg::t_cell_req                 o_cell_req,
    output mdfs_pkg::t_path_req                 o_path_req,
    output logic                                o_busy,
    output mdfs_pkg::t_result                   o_result
);

    localparam int CW = mdfs_pkg::COORD_W;
    localparam int AW = mdfs_pkg::CELL_AW;
    localparam int NW = mdfs_pkg::COUNT_W;
    localparam int DW = mdfs_pkg::DIM_W;
    localparam int LW = mdfs_pkg::LINK_W;
    localparam int RW = mdfs_pkg::RND_W;
    localparam int PW = RW + mdfs_pkg::RECIP3_SHIFT;

    mdfs_pkg::t_state r_state, n_state;

    // Latched command beat.
    mdfs_pkg::t_cmd   r_cmd, n_cmd;
    logic [AW-1:0]    r_cidx, n_cidx;
    logic [LW-1:0]    r_links, n_links;
    logic [RW-1:0]    r_rnd, n_rnd;

    // Walker state.
    logic [CW-1:0]    r_cur_x, n_cur_x;
    logic [CW-1:0]    r_cur_y, n_cur_y;
    logic [NW-1:0]    r_count, n_count;
    logic             r_stuck, n_stuck;

    // Step working registers.
    logic [NW-1:0]        r_base, n_base;
    logic [RW-1:0]        r_q3, n_q3;
    logic [2:0]           r_rd, n_rd;
    logic [LW-1:0]        r_here, n_here;
    logic [3:0]           r_nb_expl, n_nb_expl;
    logic [3:0][LW-1:0]   r_nb_links, n_nb_links;

    // Path read-back.
    logic [CW-1:0]    r_rd_x, n_rd_x;
    logic [CW-1:0]    r_rd_y, n_rd_y;

    mdfs_pkg::t_result r_out, n_out;

    // Derived values.
    logic             at_corner;
    logic             in_grid;
    logic [3:0]       nb_ok;
    logic [3:0]       open;
    logic [2:0]       open_cnt;
    logic [RW-1:0]    mod3_full;
    logic [1:0]       pick_k;
    mdfs_pkg::t_dir   pick_dir;
    logic [3:0][NW-1:0] nb_addr;
    logic [1:0]       rd_dir;
    logic [PW-1:0]    q3_prod;
    logic [NW-1:0]    pop_count;
    logic [CW-1:0]    mv_x;
    logic [CW-1:0]    mv_y;

    // Position checks against the effective grid.
    assign at_corner = ({1'b0, r_cur_x} == i_grid.w - DW'(1))
                    && ({1'b0, r_cur_y} == i_grid.h - DW'(1));
    assign in_grid   = ({1'b0, r_cur_x} < i_grid.w) && ({1'b0, r_cur_y} < i_grid.h);

    always_comb begin
        nb_ok[mdfs_pkg::DIR_RIGHT] = ({1'b0, r_cur_x} + DW'(1)) < i_grid.w;
        nb_ok[mdfs_pkg::DIR_LEFT]  = (r_cur_x != '0);
        nb_ok[mdfs_pkg::DIR_UP]    = ({1'b0, r_cur_y} + DW'(1)) < i_grid.h;
        nb_ok[mdfs_pkg::DIR_DOWN]  = (r_cur_y != '0);
    end

    // Neighbour addresses around the current cell.
    always_comb begin
        nb_addr[mdfs_pkg::DIR_RIGHT] = r_base + NW'(1);
        nb_addr[mdfs_pkg::DIR_LEFT]  = r_base - NW'(1);
        nb_addr[mdfs_pkg::DIR_UP]    = r_base + NW'(i_grid.w);
        nb_addr[mdfs_pkg::DIR_DOWN]  = r_base - NW'(i_grid.w);
    end

    // Quotient by three through the reciprocal, registered before use.
    assign q3_prod   = PW'(r_rnd) * PW'(mdfs_pkg::RECIP3);
    assign mod3_full = r_rnd - {r_q3[RW-2:0], 1'b0} - r_q3;

    assign rd_dir = 2'(r_rd - 3'd2);

    // Open directions and the pick among them.
    always_comb begin
        logic [2:0] seen;
        logic       found;
        open     = {4{in_grid}} & nb_ok & ~r_nb_expl & r_here;
        open_cnt = 3'($countones(open));
        pick_k   = '0;
        unique case (open_cnt)
            3'd2:    pick_k = {1'b0, r_rnd[0]};
            3'd3:    pick_k = mod3_full[1:0];
            3'd4:    pick_k = r_rnd[1:0];
            default: pick_k = '0;
        endcase
        seen     = '0;
        found    = 1'b0;
        pick_dir = mdfs_pkg::DIR_RIGHT;
        for (int d = 0; d < 4; d++) begin
            if (open[d] && !found && (seen == {1'b0, pick_k})) begin
                pick_dir = mdfs_pkg::t_dir'(2'(d));
                found    = 1'b1;
            end
            if (open[d]) begin
                seen = seen + 3'd1;
            end
        end
    end

    // Position after a move in the picked direction.
    always_comb begin
        mv_x = r_cur_x;
        mv_y = r_cur_y;
        unique case (pick_dir)
            mdfs_pkg::DIR_RIGHT: mv_x = r_cur_x + CW'(1);
            mdfs_pkg::DIR_LEFT:  mv_x = r_cur_x - CW'(1);
            mdfs_pkg::DIR_UP:    mv_y = r_cur_y + CW'(1);
            mdfs_pkg::DIR_DOWN:  mv_y = r_cur_y - CW'(1);
        endcase
    end

    assign pop_count = (r_count == '0) ? '0 : r_count - NW'(1);

    // State register and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mdfs_pkg::S_IDLE;
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_count <= '0;
            r_stuck <= 1'b0;
            r_out   <= '0;
        end else begin
            r_state <= n_state;
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_count <= n_count;
            r_stuck <= n_stuck;
            r_out   <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_cidx     <= n_cidx;
        r_links    <= n_links;
        r_rnd      <= n_rnd;
        r_base     <= n_base;
        r_q3       <= n_q3;
        r_rd       <= n_rd;
        r_here     <= n_here;
        r_nb_expl  <= n_nb_expl;
        r_nb_links <= n_nb_links;
        r_rd_x     <= n_rd_x;
        r_rd_y     <= n_rd_y;
    end

    // Next state and memory requests.
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_cidx     = r_cidx;
        n_links    = r_links;
        n_rnd      = r_rnd;
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_count    = r_count;
        n_stuck    = r_stuck;
        n_base     = r_base;
        n_q3       = r_q3;
        n_rd       = r_rd;
        n_here     = r_here;
        n_nb_expl  = r_nb_expl;
        n_nb_links = r_nb_links;
        n_rd_x     = r_rd_x;
        n_rd_y     = r_rd_y;
        n_out      = r_out;
        n_out.valid = 1'b0;
        o_cell_req = '0;
        o_path_req = '0;

        unique case (r_state)
            mdfs_pkg::S_IDLE: begin
                if (i_start) begin
                    n_cmd   = mdfs_pkg::t_cmd'(i_command);
                    n_cidx  = i_cell_index;
                    n_links = i_cell_links;
                    n_rnd   = i_random_value;
                    unique case (mdfs_pkg::t_cmd'(i_command))
                        mdfs_pkg::CMD_WRITE: n_state = mdfs_pkg::S_WRITE;
                        mdfs_pkg::CMD_START: n_state = mdfs_pkg::S_ST_RD;
                        mdfs_pkg::CMD_STEP: begin
                            if (r_stuck || at_corner) begin
                                n_state = mdfs_pkg::S_RESULT;
                            end else begin
                                n_state = mdfs_pkg::S_BASE;
                            end
                        end
                        mdfs_pkg::CMD_READ: begin
                            if ({1'b0, i_path_index} < r_count) begin
                                o_path_req.raddr = i_path_index;
                                n_state          = mdfs_pkg::S_RD_PATH;
                            end else begin
                                n_rd_x  = '0;
                                n_rd_y  = '0;
                                n_state = mdfs_pkg::S_RESULT;
                            end
                        end
                    endcase
                end
            end

            // Cell write: new links, explored mark cleared.
            mdfs_pkg::S_WRITE: begin
                o_cell_req.we    = ({1'b0, r_cidx} < NW'(mdfs_pkg::CELL_COUNT));
                o_cell_req.waddr = r_cidx;
                o_cell_req.wdata = {1'b0, r_links};
                n_state          = mdfs_pkg::S_RESULT;
            end

            // Start: fetch the origin cell so that its links survive the mark.
            mdfs_pkg::S_ST_RD: begin
                o_cell_req.raddr = '0;
                n_state          = mdfs_pkg::S_ST_WR;
            end

            mdfs_pkg::S_ST_WR: begin
                o_cell_req.we    = 1'b1;
                o_cell_req.waddr = '0;
                o_cell_req.wdata = {1'b1, i_cell_rdata[LW-1:0]};
                o_path_req.we    = 1'b1;
                o_path_req.waddr = '0;
                o_path_req.wdata = '0;
                n_cur_x          = '0;
                n_cur_y          = '0;
                n_stuck          = 1'b0;
                n_count          = NW'(1);
                n_state          = mdfs_pkg::S_RESULT;
            end

            // Step: address of the current cell and quotient of the random beat.
            mdfs_pkg::S_BASE: begin
                n_base  = NW'(r_cur_y) * NW'(i_grid.w) + NW'(r_cur_x);
                n_q3    = q3_prod[PW-1:mdfs_pkg::RECIP3_SHIFT];
                n_rd    = '0;
                n_state = mdfs_pkg::S_READ;
            end

            // Five reads, each captured from the registered read port.
            mdfs_pkg::S_READ: begin
                if (r_rd == '0) begin
                    o_cell_req.raddr = r_base[AW-1:0];
                end else begin
                    o_cell_req.raddr = nb_addr[2'(r_rd - 3'd1)][AW-1:0];
                end
                if (r_rd == 3'd1) begin
                    n_here = i_cell_rdata[LW-1:0];
                end else if (r_rd >= 3'd2) begin
                    n_nb_expl[rd_dir]  = i_cell_rdata[mdfs_pkg::EXPLORED_BIT];
                    n_nb_links[rd_dir] = i_cell_rdata[LW-1:0];
                end
                n_rd = r_rd + 3'd1;
                if (r_rd == mdfs_pkg::READ_SLOTS) begin
                    n_state = mdfs_pkg::S_PICK;
                end
            end

            // Move, mark and push, or pop back to the previous position.
            mdfs_pkg::S_PICK: begin
                if (open_cnt != '0) begin
                    n_cur_x          = mv_x;
                    n_cur_y          = mv_y;
                    o_cell_req.we    = 1'b1;
                    o_cell_req.waddr = nb_addr[pick_dir][AW-1:0];
                    o_cell_req.wdata = {1'b1, r_nb_links[pick_dir]};
                    if (r_count < NW'(mdfs_pkg::CELL_COUNT)) begin
                        o_path_req.we    = 1'b1;
                        o_path_req.waddr = r_count[AW-1:0];
                        o_path_req.wdata = {mv_x, mv_y};
                        n_count          = r_count + NW'(1);
                    end
                    n_state = mdfs_pkg::S_RESULT;
                end else begin
                    n_count = pop_count;
                    if (pop_count == '0) begin
                        n_stuck = 1'b1;
                        n_state = mdfs_pkg::S_RESULT;
                    end else begin
                        o_path_req.raddr = AW'(pop_count - NW'(1));
                        n_state          = mdfs_pkg::S_POP;
                    end
                end
            end

            mdfs_pkg::S_POP: begin
                n_cur_x = i_path_rdata[2*CW-1:CW];
                n_cur_y = i_path_rdata[CW-1:0];
                n_state = mdfs_pkg::S_RESULT;
            end

            mdfs_pkg::S_RD_PATH: begin
                n_rd_x  = i_path_rdata[2*CW-1:CW];
                n_rd_y  = i_path_rdata[CW-1:0];
                n_state = mdfs_pkg::S_RESULT;
            end

            // Load the result beat; it shows for one cycle.
            mdfs_pkg::S_RESULT: begin
                n_out.valid = 1'b1;
                n_out.x     = (r_cmd == mdfs_pkg::CMD_READ) ? r_rd_x : r_cur_x;
                n_out.y     = (r_cmd == mdfs_pkg::CMD_READ) ? r_rd_y : r_cur_y;
                n_out.len   = r_count;
                n_out.done  = at_corner;
                n_out.stuck = r_stuck;
                n_state     = mdfs_pkg::S_IDLE;
            end

            default: n_state = mdfs_pkg::S_IDLE;
        endcase
    end

    assign o_busy   = (r_state != mdfs_pkg::S_IDLE);
    assign o_result = r_out;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// Maze DFS path walker testbench
// Writes the low part of the cell store, then runs a short directed sequence,
// a shuttle walk that grows the path well past the grid area, and random maze
// phases under many grid sizes. Commands go out in bursts from a pending
// queue; every result beat is checked field by field against an in-bench
// walker.
// ============================================================================
module testbench;

    localparam int CW = mdfs_pkg::COORD_W;
    localparam int AW = mdfs_pkg::CELL_AW;
    localparam int NW = mdfs_pkg::COUNT_W;
    localparam int DW = mdfs_pkg::DIM_W;
    localparam int LW = mdfs_pkg::LINK_W;
    localparam int RW = mdfs_pkg::RND_W;
    localparam int PW = mdfs_pkg::PATH_W;
    localparam int EB = mdfs_pkg::EXPLORED_BIT;

    // One command beat as it is driven onto the ports.
    typedef struct {
        mdfs_pkg::t_cmd     cmd;
        logic [AW-1:0]      cell_index;
        logic [LW-1:0]      links;
        logic [RW-1:0]      rnd;
        logic [AW-1:0]      path_index;
    } t_maze_item;

    // One result beat as the walker should report it.
    typedef struct {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [NW-1:0] len;
        logic          done;
        logic          stuck;
    } t_maze_result;

    // Grids in use never cover more than the cells written at the start.
    localparam int unsigned FILL_CELLS     = 256;
    localparam int unsigned FRESH_CELL_CAP = 160;
    localparam int unsigned PHASE_STEP_CAP = 90;
    localparam int unsigned RANDOM_ITEMS   = 1000;
    localparam int unsigned FILL_LOOPS     = 20;

    int unsigned size_extremes [5] = '{0, 1, 64, 65, 127};

    logic                                 i_clk          = 1'b0;
    logic                                 i_rst_n        = 1'b0;
    logic                                 start          = 1'b0;
    logic                                 busy;
    logic [mdfs_pkg::CMD_W-1:0]           i_command      = '0;
    logic [AW-1:0]                        i_cell_index   = '0;
    logic [LW-1:0]                        i_cell_links   = '0;
    logic [RW-1:0]                        i_random_value = '0;
    logic [AW-1:0]                        i_path_index   = '0;
    logic                                 i_cfg_we       = 1'b0;
    logic [mdfs_pkg::CFG_IDX_W-1:0]       i_cfg_index    = '0;
    logic [DW-1:0]                        i_cfg_data     = '0;
    logic                                 o_valid;
    logic [CW-1:0]                        o_pos_x;
    logic [CW-1:0]                        o_pos_y;
    logic [NW-1:0]                        o_path_length;
    logic                                 o_done_res;
    logic                                 o_stuck;

    maze_dfs_path_walker_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_cell_index   (i_cell_index),
        .i_cell_links   (i_cell_links),
        .i_random_value (i_random_value),
        .i_path_index   (i_path_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_path_length  (o_path_length),
        .o_done_res     (o_done_res),
        .o_stuck        (o_stuck)
    );

    // Commands waiting to be sent and results still owed by the block.
    t_maze_item   pending_q [$];
    t_maze_result expected_q [$];

    // Walker state kept alongside the block.
    logic [mdfs_pkg::CELL_W-1:0] cell_mem [mdfs_pkg::CELL_COUNT];
    logic [PW-1:0]      trail [mdfs_pkg::CELL_COUNT];
    int unsigned        trail_len;
    logic [CW-1:0]      walker_x;
    logic [CW-1:0]      walker_y;
    logic               stuck_q;
    logic [DW-1:0]      grid_w_reg;
    logic [DW-1:0]      grid_h_reg;

    // Sender state and run statistics.
    t_maze_item   cur_item;
    t_maze_result due;
    int           burst_left = 0;
    int           gap_left   = 0;
    int unsigned  posted     = 0;
    int unsigned  mismatch_count = 0;
    int unsigned  cmd_seen [4] = '{0, 0, 0, 0};
    int unsigned  moves_cnt = 0, backtrack_cnt = 0, drop_cnt = 0;
    int unsigned  done_cnt = 0, stuck_cnt = 0, deepest = 0, cfg_write_cnt = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Size register as the block uses it: zero acts as one, large values clip.
    function automatic int unsigned grid_extent(input logic [DW-1:0] v,
                                                input int unsigned limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    function automatic bit at_far_corner(input int unsigned w, input int unsigned h);
        return walker_x == w - 1 && walker_y == h - 1;
    endfunction

    // Push the current position; a full stack drops the entry.
    function automatic void push_trail();
        if (trail_len < mdfs_pkg::CELL_COUNT) begin
            trail[trail_len] = {walker_y, walker_x};
            trail_len++;
            if (trail_len > deepest) deepest = trail_len;
        end else begin
            drop_cnt++;
        end
    endfunction

    // Apply one accepted command to the walker and record the result it owes.
    task automatic apply_command(input t_maze_item it);
        int unsigned    w, h, x, y, n;
        mdfs_pkg::t_dir open_dirs [4];
        mdfs_pkg::t_dir pick;
        logic [LW-1:0]  here;
        t_maze_result   r;
        w = grid_extent(grid_w_reg, mdfs_pkg::MAX_WIDTH);
        h = grid_extent(grid_h_reg, mdfs_pkg::MAX_HEIGHT);
        cmd_seen[it.cmd]++;
        case (it.cmd)
            mdfs_pkg::CMD_WRITE: begin
                cell_mem[it.cell_index] = {1'b0, it.links};
            end
            mdfs_pkg::CMD_START: begin
                walker_x  = '0;
                walker_y  = '0;
                stuck_q   = 1'b0;
                trail_len = 0;
                cell_mem[0][EB] = 1'b1;
                push_trail();
            end
            mdfs_pkg::CMD_STEP: begin
                if (!stuck_q && !at_far_corner(w, h)) begin
                    x = walker_x;
                    y = walker_y;
                    n = 0;
                    // A position left outside a shrunken grid sees no way out.
                    if (x < w && y < h) begin
                        here = cell_mem[y * w + x][LW-1:0];
                        if (here[mdfs_pkg::DIR_RIGHT] && x + 1 < w
                                && !cell_mem[y * w + x + 1][EB]) begin
                            open_dirs[n] = mdfs_pkg::DIR_RIGHT;
                            n++;
                        end
                        if (here[mdfs_pkg::DIR_LEFT] && x > 0
                                && !cell_mem[y * w + x - 1][EB]) begin
                            open_dirs[n] = mdfs_pkg::DIR_LEFT;
                            n++;
                        end
                        if (here[mdfs_pkg::DIR_UP] && y + 1 < h
                                && !cell_mem[(y + 1) * w + x][EB]) begin
                            open_dirs[n] = mdfs_pkg::DIR_UP;
                            n++;
                        end
                        if (here[mdfs_pkg::DIR_DOWN] && y > 0
                                && !cell_mem[(y - 1) * w + x][EB]) begin
                            open_dirs[n] = mdfs_pkg::DIR_DOWN;
                            n++;
                        end
                    end
                    if (n > 0) begin
                        pick = open_dirs[it.rnd % n];
                        case (pick)
                            mdfs_pkg::DIR_RIGHT: x = x + 1;
                            mdfs_pkg::DIR_LEFT:  x = x - 1;
                            mdfs_pkg::DIR_UP:    y = y + 1;
                            mdfs_pkg::DIR_DOWN:  y = y - 1;
                        endcase
                        walker_x = CW'(x);
                        walker_y = CW'(y);
                        cell_mem[y * w + x][EB] = 1'b1;
                        push_trail();
                        moves_cnt++;
                    end else begin
                        // Dead end: pop and return to the new top, or give up.
                        backtrack_cnt++;
                        if (trail_len > 0) trail_len--;
                        if (trail_len == 0) stuck_q = 1'b1;
                        else {walker_y, walker_x} = trail[trail_len - 1];
                    end
                end
            end
            default: ;
        endcase
        r.x = walker_x;
        r.y = walker_y;
        if (it.cmd == mdfs_pkg::CMD_READ) begin
            if (it.path_index < trail_len) {r.y, r.x} = trail[it.path_index];
            else {r.y, r.x} = '0;
        end
        r.len   = NW'(trail_len);
        r.done  = at_far_corner(w, h);
        r.stuck = stuck_q;
        if (r.done) done_cnt++;
        if (r.stuck) stuck_cnt++;
        expected_q.insert(expected_q.size(), r);
    endtask

    // Queue one command; a negative argument leaves that field random.
    function automatic void post(input mdfs_pkg::t_cmd c, input int cell_sel, input int lnk,
                                 input int rnd, input int slot);
        t_maze_item it;
        it.cmd        = c;
        it.cell_index = (cell_sel < 0) ? AW'($urandom) : AW'(cell_sel);
        it.links      = (lnk < 0) ? LW'($urandom) : LW'(lnk);
        it.rnd        = (rnd < 0) ? RW'($urandom) : RW'(rnd);
        it.path_index = (slot < 0) ? AW'($urandom) : AW'(slot);
        pending_q.insert(pending_q.size(), it);
        posted++;
    endfunction

    // Wait until the block has drained every command and owes nothing.
    task automatic settle();
        do @(negedge i_clk);
        while (pending_q.size() != 0 || expected_q.size() != 0 || start || busy);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_grid(input logic [DW-1:0] wv, input logic [DW-1:0] hv);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= mdfs_pkg::REG_GRID_WIDTH;
        i_cfg_data  <= wv;
        @(posedge i_clk);
        i_cfg_index <= mdfs_pkg::REG_GRID_HEIGHT;
        i_cfg_data  <= hv;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_write_cnt += 2;
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [NW-1:0] want_v,
                               input logic [NW-1:0] got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // Sender: tracks the walker on each accepted beat and feeds the next
    // command in bursts separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start      <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
            trail_len  = 0;
            walker_x   = '0;
            walker_y   = '0;
            stuck_q    = 1'b0;
            grid_w_reg = mdfs_pkg::GRID_RESET;
            grid_h_reg = mdfs_pkg::GRID_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mdfs_pkg::REG_GRID_WIDTH:  grid_w_reg = i_cfg_data;
                    mdfs_pkg::REG_GRID_HEIGHT: grid_h_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) apply_command(cur_item);
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    cur_item = pending_q.pop_front();
                    i_command      <= cur_item.cmd;
                    i_cell_index   <= cur_item.cell_index;
                    i_cell_links   <= cur_item.links;
                    i_random_value <= cur_item.rnd;
                    i_path_index   <= cur_item.path_index;
                    start          <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        // Mostly short bursts with gaps, now and then a long
                        // back-to-back run.
                        if ($urandom_range(0, 3) == 0) begin
                            burst_left = $urandom_range(20, 60);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 8);
                            gap_left   = $urandom_range(1, 5);
                        end
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Receiver: every result beat must match the oldest outstanding result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                $error("result beat with no command outstanding");
                mismatch_count++;
            end else begin
                due = expected_q.pop_front();
                check_field("pos_x", due.x, o_pos_x);
                check_field("pos_y", due.y, o_pos_y);
                check_field("path_length", due.len, o_path_length);
                check_field("done_res", due.done, o_done_res);
                check_field("stuck", due.stuck, o_stuck);
            end
        end
    end

    // Stimulus.
    initial begin
        int unsigned rand_base, w, h, cells, nsteps, r, k;
        logic [DW-1:0] wv, hv, tv;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The low cells get written once; every grid below stays inside them,
        // so no step ever reads an unset cell.
        for (int i = 0; i < FILL_CELLS; i++) post(mdfs_pkg::CMD_WRITE, i, -1, -1, -1);
        settle();

        // Directed: a step before any start strands the walker, then a small
        // walk at the reset grid size with reads inside and beyond the path.
        post(mdfs_pkg::CMD_WRITE, 0, 0, -1, -1);
        post(mdfs_pkg::CMD_STEP, -1, -1, -1, -1);
        post(mdfs_pkg::CMD_STEP, -1, -1, -1, -1);
        post(mdfs_pkg::CMD_READ, -1, -1, -1, 0);
        post(mdfs_pkg::CMD_WRITE, 0, 15, -1, -1);
        post(mdfs_pkg::CMD_WRITE, 1, 15, -1, -1);
        post(mdfs_pkg::CMD_WRITE, 10, 15, -1, -1);
        post(mdfs_pkg::CMD_WRITE, 11, 15, -1, -1);
        post(mdfs_pkg::CMD_START, -1, -1, -1, -1);
        post(mdfs_pkg::CMD_STEP, -1, -1, 16'hFFFF, -1);
        post(mdfs_pkg::CMD_STEP, -1, -1, 0, -1);
        post(mdfs_pkg::CMD_STEP, -1, -1, 2, -1);
        post(mdfs_pkg::CMD_STEP, -1, -1, 1, -1);
        post(mdfs_pkg::CMD_STEP, -1, -1, -1, -1);
        post(mdfs_pkg::CMD_READ, -1, -1, -1, 0);
        post(mdfs_pkg::CMD_READ, -1, -1, -1, 2);
        post(mdfs_pkg::CMD_READ, -1, -1, -1, 4095);
        post(mdfs_pkg::CMD_START, -1, -1, -1, -1);
        settle();

        // Zero sizes act as a single cell: the walk is over as it starts.
        set_grid(0, 0);
        post(mdfs_pkg::CMD_START, -1, -1, -1, -1);
        post(mdfs_pkg::CMD_STEP, -1, -1, -1, -1);
        post(mdfs_pkg::CMD_READ, -1, -1, -1, 0);
        settle();

        // Shuttle between two cells, clearing each mark behind the walker, so
        // the path grows far beyond the number of cells in the grid.
        set_grid(2, 2);
        post(mdfs_pkg::CMD_WRITE, 0, 1 << mdfs_pkg::DIR_RIGHT, -1, -1);
        post(mdfs_pkg::CMD_WRITE, 1, 1 << mdfs_pkg::DIR_LEFT, -1, -1);
        post(mdfs_pkg::CMD_WRITE, 2, 0, -1, -1);
        post(mdfs_pkg::CMD_WRITE, 3, 0, -1, -1);
        post(mdfs_pkg::CMD_START, -1, -1, -1, -1);
        for (int i = 0; i < FILL_LOOPS; i++) begin
            post(mdfs_pkg::CMD_STEP, -1, -1, -1, -1);
            post(mdfs_pkg::CMD_WRITE, 0, 1 << mdfs_pkg::DIR_RIGHT, -1, -1);
            post(mdfs_pkg::CMD_STEP, -1, -1, -1, -1);
            post(mdfs_pkg::CMD_WRITE, 1, 1 << mdfs_pkg::DIR_LEFT, -1, -1);
        end
        post(mdfs_pkg::CMD_READ, -1, -1, -1, 4095);
        post(mdfs_pkg::CMD_READ, -1, -1, -1, 0);
        post(mdfs_pkg::CMD_READ, -1, -1, -1, 1);
        settle();

        // Random phases: a fresh maze and a start, then mostly steps with
        // reads, stray writes and restarts mixed in. Some phases keep the old
        // walk under a new grid size.
        rand_base = posted;
        while (posted - rand_base < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                // One side at an edge value, the other kept short so that the
                // area stays inside the written cells.
                wv = DW'(size_extremes[$urandom_range(0, 4)]);
                hv = DW'($urandom_range(0, 3));
                if ($urandom_range(0, 1) == 1) begin
                    tv = wv;
                    wv = hv;
                    hv = tv;
                end
            end else if (r == 1) begin
                wv = DW'($urandom_range(1, 2));
                hv = DW'($urandom_range(1, 4));
            end else begin
                wv = DW'($urandom_range(2, 8));
                hv = DW'($urandom_range(2, 8));
            end
            set_grid(wv, hv);
            w = grid_extent(wv, mdfs_pkg::MAX_WIDTH);
            h = grid_extent(hv, mdfs_pkg::MAX_HEIGHT);
            cells = w * h;
            if ($urandom_range(0, 4) != 0) begin
                for (int i = 0; i < cells && i < FRESH_CELL_CAP; i++)
                    post(mdfs_pkg::CMD_WRITE, i,
                         int'($urandom_range(0, 15) | $urandom_range(0, 15)), -1, -1);
                post(mdfs_pkg::CMD_START, -1, -1, -1, -1);
            end
            nsteps = 2 * cells + 6;
            if (nsteps > PHASE_STEP_CAP) nsteps = PHASE_STEP_CAP;
            for (k = 0; k < nsteps; k++) begin
                r = $urandom_range(0, 99);
                if (r < 78) post(mdfs_pkg::CMD_STEP, -1, -1, -1, -1);
                else if (r < 88)
                    post(mdfs_pkg::CMD_READ, -1, -1, -1,
                         ($urandom_range(0, 3) == 0) ? -1
                                                     : int'($urandom_range(0, cells + 2)));
                else if (r < 95)
                    post(mdfs_pkg::CMD_WRITE,
                         ($urandom_range(0, 3) == 0) ? -1
                                                     : int'($urandom_range(0, cells - 1)),
                         -1, -1, -1);
                else post(mdfs_pkg::CMD_START, -1, -1, -1, -1);
            end
            settle();
        end

        settle();
        repeat (30) @(posedge i_clk);
        $display("Covered %0d writes, %0d starts, %0d steps, %0d path reads, %0d size writes.",
                 cmd_seen[mdfs_pkg::CMD_WRITE], cmd_seen[mdfs_pkg::CMD_START],
                 cmd_seen[mdfs_pkg::CMD_STEP], cmd_seen[mdfs_pkg::CMD_READ],
                 cfg_write_cnt);
        $display("Walk made %0d moves, %0d backtracks, depth %0d, %0d dropped pushes,",
                 moves_cnt, backtrack_cnt, deepest, drop_cnt);
        $display("and reported %0d done beats and %0d stuck beats.", done_cnt, stuck_cnt);
        if (mismatch_count == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    // Watchdog for a block that stops answering.
    initial begin
        #3_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
